// ===== hdl/xasd_pkg.sv =====
`default_nettype none
package xasd_pkg;

    // sectoring
    localparam int BLOCKS_PER_SECTOR = 256;
    localparam int BLK_W = (BLOCKS_PER_SECTOR > 1) ? $clog2(BLOCKS_PER_SECTOR) : 1;

    // round key store: eleven tweak keys, then eleven data keys, 128 bits each
    localparam int NUM_ROUNDS = 10;
    localparam int RND_W      = 4;
    localparam int RK_DEPTH   = 2 * (NUM_ROUNDS + 1);
    localparam int RK_AW      = $clog2(RK_DEPTH);
    localparam int TW_BASE    = 0;
    localparam int DAT_BASE   = NUM_ROUNDS + 1;

    // configuration register indexes
    localparam int CFG_AW = 3;
    localparam logic [CFG_AW-1:0] REG_DATA_KEY_LO  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_DATA_KEY_HI  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_TWEAK_KEY_LO = 3'd2;
    localparam logic [CFG_AW-1:0] REG_TWEAK_KEY_HI = 3'd3;
    localparam logic [CFG_AW-1:0] REG_FIRST_SECTOR = 3'd4;

    // gf(2^128) reduction and key schedule constants
    localparam logic [127:0] GF_POLY   = 128'h87;
    localparam logic [7:0]   RCON_INIT = 8'h01;
    localparam logic [7:0]   AES_POLY  = 8'h1b;

    typedef enum logic [2:0] {
        S_IDLE,
        S_KEXP,
        S_TW_RUN,
        S_DEC_RUN,
        S_DONE
    } t_state;

    // controls of the shared round unit
    typedef struct packed {
        logic inverse;
        logic add_only;
        logic no_mix;
    } t_round_ctl;

    // round key write request
    typedef struct packed {
        logic             we;
        logic [RK_AW-1:0] addr;
        logic [127:0]     data;
    } t_rk_wr;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? AES_POLY : 8'h00);
    endfunction

    // multiply by alpha in gf(2^128)
    function automatic logic [127:0] gf_alpha(input logic [127:0] t);
        return {t[126:0], 1'b0} ^ (t[127] ? GF_POLY : 128'h0);
    endfunction

endpackage
`default_nettype wire

// ===== hdl/xasd_round.sv =====
`default_nettype none
module xasd_round (
    input  wire logic [127:0]        i_state,
    input  wire logic [127:0]        i_key,
    input  wire xasd_pkg::t_round_ctl i_ctl,
    output logic [127:0]             o_state
);
    import xasd_pkg::*;

    logic [7:0]   s_b   [16];
    logic [7:0]   e_sub [16];
    logic [7:0]   d_sub [16];
    logic [127:0] e_sr;
    logic [127:0] e_mix;
    logic [127:0] d_add;
    logic [127:0] d_mix;

    // byte view of the state
    always_comb begin
        for (int k = 0; k < 16; k++) begin
            s_b[k] = i_state[8*k +: 8];
        end
    end

    // forward: sub bytes and shift rows
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                e_sub[i + 4*c] = SBOX[s_b[i + 4*((c + i) % 4)]];
            end
        end
        for (int k = 0; k < 16; k++) begin
            e_sr[8*k +: 8] = e_sub[k];
        end
    end

    // forward mix columns
    always_comb begin
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = e_sub[4*c];
            a1 = e_sub[4*c+1];
            a2 = e_sub[4*c+2];
            a3 = e_sub[4*c+3];
            e_mix[32*c +: 8]      = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            e_mix[32*c+8 +: 8]    = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            e_mix[32*c+16 +: 8]   = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            e_mix[32*c+24 +: 8]   = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
    end

    // inverse: shift rows and sub bytes, then key
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                d_sub[i + 4*((c + i) % 4)] = INV_SBOX[s_b[i + 4*c]];
            end
        end
        for (int k = 0; k < 16; k++) begin
            d_add[8*k +: 8] = d_sub[k] ^ i_key[8*k +: 8];
        end
    end

    // inverse mix columns
    always_comb begin
        logic [7:0] a [4];
        logic [7:0] m9 [4];
        logic [7:0] m11 [4];
        logic [7:0] m13 [4];
        logic [7:0] m14 [4];
        logic [7:0] x2, x4, x8;
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                a[j]   = d_add[32*c + 8*j +: 8];
                x2     = xtime(a[j]);
                x4     = xtime(x2);
                x8     = xtime(x4);
                m9[j]  = x8 ^ a[j];
                m11[j] = x8 ^ x2 ^ a[j];
                m13[j] = x8 ^ x4 ^ a[j];
                m14[j] = x8 ^ x4 ^ x2;
            end
            d_mix[32*c +: 8]    = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
            d_mix[32*c+8 +: 8]  = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
            d_mix[32*c+16 +: 8] = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
            d_mix[32*c+24 +: 8] = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
        end
    end

    // result select
    always_comb begin
        if (i_ctl.add_only) begin
            o_state = i_state ^ i_key;
        end else if (i_ctl.inverse) begin
            o_state = i_ctl.no_mix ? d_add : d_mix;
        end else begin
            o_state = (i_ctl.no_mix ? e_sr : e_mix) ^ i_key;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/xasd_key_sched.sv =====
`default_nettype none
module xasd_key_sched (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic             i_sel_tweak,
    input  wire logic [127:0]     i_key,
    output logic                  o_busy,
    output xasd_pkg::t_rk_wr      o_wr
);
    import xasd_pkg::*;

    logic             r_busy, n_busy;
    logic [RND_W-1:0] r_cnt, n_cnt;
    logic [127:0]     r_key, n_key;
    logic [7:0]       r_rcon, n_rcon;
    logic [RK_AW-1:0] r_base, n_base;
    logic [31:0]      t_word;
    logic [127:0]     nxt_key;

    // next round key from the last word
    always_comb begin
        t_word[7:0]   = SBOX[r_key[111:104]] ^ r_rcon;
        t_word[15:8]  = SBOX[r_key[119:112]];
        t_word[23:16] = SBOX[r_key[127:120]];
        t_word[31:24] = SBOX[r_key[103:96]];
        nxt_key[31:0]   = r_key[31:0] ^ t_word;
        nxt_key[63:32]  = r_key[63:32] ^ nxt_key[31:0];
        nxt_key[95:64]  = r_key[95:64] ^ nxt_key[63:32];
        nxt_key[127:96] = r_key[127:96] ^ nxt_key[95:64];
    end

    // sequencer
    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_key  = r_key;
        n_rcon = r_rcon;
        n_base = r_base;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_key  = i_key;
            n_rcon = RCON_INIT;
            n_base = i_sel_tweak ? RK_AW'(TW_BASE) : RK_AW'(DAT_BASE);
        end else if (r_busy) begin
            n_key  = nxt_key;
            n_rcon = xtime(r_rcon);
            n_cnt  = r_cnt + 1'b1;
            if (r_cnt == RND_W'(NUM_ROUNDS)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_key  <= n_key;
        r_rcon <= n_rcon;
        r_base <= n_base;
    end

    // one round key written per cycle
    assign o_busy    = r_busy;
    assign o_wr.we   = r_busy;
    assign o_wr.addr = r_base + RK_AW'(r_cnt);
    assign o_wr.data = r_key;

endmodule
`default_nettype wire

// ===== hdl/xts_aes128_sector_decrypt_top.sv =====
`default_nettype none
// channel   direction  handshake                 payload
// in        to block   i_in_valid / o_in_ready   i_cipher_low, i_cipher_high
// out       from block o_out_valid / i_out_ready o_plain_low, o_plain_high
// cfg       to block   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// a block goes through the accept cycle in idle, eleven passes of the shared round unit
// and one output load, which waits while the output register holds a result not yet taken.
// the first block of a sector adds eleven passes for the tweak encryption.
// a key write runs the key schedule, one round key per cycle into the key memory, and
// then returns to idle; nothing is accepted until the block is back in idle.
// reset is synchronous, active low, and clears key registers, tweak and counters.
// the next block is accepted while a result still waits in the output register.
module xts_aes128_sector_decrypt_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [63:0]                 i_cipher_low,
    input  wire logic [63:0]                 i_cipher_high,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [63:0]                      o_plain_low,
    output logic [63:0]                      o_plain_high,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [xasd_pkg::CFG_AW-1:0] i_cfg_index,
    input  wire logic [63:0]                 i_cfg_data
);
    import xasd_pkg::*;

    t_state           r_state, n_state;
    logic [RND_W-1:0] r_rnd;
    logic [127:0]     r_s;
    logic [127:0]     r_cin;
    logic [127:0]     r_tweak;
    logic [BLK_W-1:0] r_blk;
    logic [63:0]      r_sector;
    logic [63:0]      r_dk_lo, r_dk_hi, r_tk_lo, r_tk_hi;
    logic             r_out_valid;
    logic [127:0]     r_out;
    logic [127:0]     r_rk_rd;
    logic [127:0]     r_rk_mem [RK_DEPTH];

    logic             in_acc, cfg_acc, out_load, last_rnd;
    logic             ks_start, ks_sel_tweak, ks_busy;
    logic [127:0]     ks_key;
    t_rk_wr           ks_wr;
    t_round_ctl       rnd_ctl;
    logic [RK_AW-1:0] rk_raddr;
    logic [127:0]     rnd_out;

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_valid;
    assign in_acc      = i_in_valid && o_in_ready;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign last_rnd    = (r_rnd == RND_W'(NUM_ROUNDS));
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // key writes start the schedule with the updated key
    always_comb begin
        ks_start     = 1'b0;
        ks_sel_tweak = 1'b0;
        ks_key       = {r_dk_hi, r_dk_lo};
        if (cfg_acc) begin
            case (i_cfg_index)
                REG_DATA_KEY_LO: begin
                    ks_start = 1'b1;
                    ks_key   = {r_dk_hi, i_cfg_data};
                end
                REG_DATA_KEY_HI: begin
                    ks_start = 1'b1;
                    ks_key   = {i_cfg_data, r_dk_lo};
                end
                REG_TWEAK_KEY_LO: begin
                    ks_start     = 1'b1;
                    ks_sel_tweak = 1'b1;
                    ks_key       = {r_tk_hi, i_cfg_data};
                end
                REG_TWEAK_KEY_HI: begin
                    ks_start     = 1'b1;
                    ks_sel_tweak = 1'b1;
                    ks_key       = {i_cfg_data, r_tk_lo};
                end
                default: ks_start = 1'b0;
            endcase
        end
    end

    xasd_key_sched u_key_sched (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (ks_start),
        .i_sel_tweak (ks_sel_tweak),
        .i_key       (ks_key),
        .o_busy      (ks_busy),
        .o_wr        (ks_wr)
    );

    // round key memory
    always_ff @(posedge i_clk) begin
        if (ks_wr.we) begin
            r_rk_mem[ks_wr.addr] <= ks_wr.data;
        end
        r_rk_rd <= r_rk_mem[rk_raddr];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (ks_start) begin
                    n_state = S_KEXP;
                end else if (in_acc) begin
                    n_state = (r_blk == '0) ? S_TW_RUN : S_DEC_RUN;
                end
            end
            S_KEXP: begin
                if (!ks_busy) begin
                    n_state = S_IDLE;
                end
            end
            S_TW_RUN: begin
                if (last_rnd) begin
                    n_state = S_DEC_RUN;
                end
            end
            S_DEC_RUN: begin
                if (last_rnd) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // round unit control and key read address
    always_comb begin
        rnd_ctl  = '0;
        rk_raddr = '0;
        case (r_state)
            S_IDLE: begin
                rk_raddr = (r_blk == '0) ? RK_AW'(TW_BASE)
                                         : RK_AW'(DAT_BASE + NUM_ROUNDS);
            end
            S_TW_RUN: begin
                rnd_ctl.add_only = (r_rnd == '0);
                rnd_ctl.no_mix   = last_rnd;
                rk_raddr = last_rnd ? RK_AW'(DAT_BASE + NUM_ROUNDS)
                                    : RK_AW'(TW_BASE) + RK_AW'(r_rnd) + 1'b1;
            end
            S_DEC_RUN: begin
                rnd_ctl.inverse  = 1'b1;
                rnd_ctl.add_only = (r_rnd == '0);
                rnd_ctl.no_mix   = last_rnd;
                rk_raddr = last_rnd ? '0
                                    : RK_AW'(DAT_BASE + NUM_ROUNDS - 1) - RK_AW'(r_rnd);
            end
            default: rk_raddr = '0;
        endcase
    end

    xasd_round u_round (
        .i_state (r_s),
        .i_key   (r_rk_rd),
        .i_ctl   (rnd_ctl),
        .o_state (rnd_out)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rnd       <= '0;
            r_blk       <= '0;
            r_sector    <= '0;
            r_tweak     <= '0;
            r_out_valid <= 1'b0;
            r_dk_lo     <= '0;
            r_dk_hi     <= '0;
            r_tk_lo     <= '0;
            r_tk_hi     <= '0;
        end else begin
            r_state <= n_state;
            // configuration writes
            if (cfg_acc) begin
                case (i_cfg_index)
                    REG_DATA_KEY_LO:  r_dk_lo <= i_cfg_data;
                    REG_DATA_KEY_HI:  r_dk_hi <= i_cfg_data;
                    REG_TWEAK_KEY_LO: r_tk_lo <= i_cfg_data;
                    REG_TWEAK_KEY_HI: r_tk_hi <= i_cfg_data;
                    REG_FIRST_SECTOR: begin
                        r_sector <= i_cfg_data;
                        r_blk    <= '0;
                    end
                    default: r_blk <= r_blk;
                endcase
            end
            // round counter
            if (in_acc || ((r_state == S_TW_RUN || r_state == S_DEC_RUN) && last_rnd)) begin
                r_rnd <= '0;
            end else if (r_state == S_TW_RUN || r_state == S_DEC_RUN) begin
                r_rnd <= r_rnd + 1'b1;
            end
            // tweak formed at sector start, advanced after each block
            if (r_state == S_TW_RUN && last_rnd) begin
                r_tweak <= rnd_out;
            end else if (r_state == S_DEC_RUN && last_rnd) begin
                r_tweak <= gf_alpha(r_tweak);
                if (r_blk == BLK_W'(BLOCKS_PER_SECTOR - 1)) begin
                    r_blk    <= '0;
                    r_sector <= r_sector + 64'd1;
                end else begin
                    r_blk <= r_blk + 1'b1;
                end
            end
            // output register
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working state
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cin <= {i_cipher_high, i_cipher_low};
            r_s   <= (r_blk == '0) ? {64'd0, r_sector}
                                   : ({i_cipher_high, i_cipher_low} ^ r_tweak);
        end else if (r_state == S_TW_RUN) begin
            r_s <= last_rnd ? (r_cin ^ rnd_out) : rnd_out;
        end else if (r_state == S_DEC_RUN) begin
            r_s <= last_rnd ? (rnd_out ^ r_tweak) : rnd_out;
        end
        if (out_load) begin
            r_out <= r_s;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_plain_low  = r_out[63:0];
    assign o_plain_high = r_out[127:64];

    // checks
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_TW_RUN || r_state == S_DEC_RUN))
        else $error("accepted request did not start processing");

    a_ksched_in_kexp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ks_busy |-> (r_state == S_KEXP))
        else $error("key schedule running outside key expansion");

    a_rnd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TW_RUN || r_state == S_DEC_RUN) |-> (r_rnd <= RND_W'(NUM_ROUNDS)))
        else $error("round counter out of range");

    a_sector_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_acc && i_cfg_index == REG_FIRST_SECTOR) |=> (r_blk == '0))
        else $error("sector reload did not restart block count");

endmodule
`default_nettype wire

// ===== tb/tb_xts_aes128_sector_decrypt_top.sv =====
`default_nettype none
module tb_xts_aes128_sector_decrypt_top;
    timeunit 1ns;
    timeprecision 1ps;
    import xasd_pkg::*;

    // register indexes that the block does not decode
    localparam logic [CFG_AW-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_AW-1:0] REG_SPARE_LAST  = 3'd7;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 40;

    typedef logic [7:0] t_aes_state [16];
    typedef logic [127:0] t_key_sched [11];
    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
    } t_block;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic [63:0] i_cipher_low = '0;
    logic [63:0] i_cipher_high = '0;
    logic i_out_ready = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [CFG_AW-1:0] i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;
    logic o_in_ready, o_out_valid, o_cfg_ready;
    logic [63:0] o_plain_low, o_plain_high;

    xts_aes128_sector_decrypt_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_cipher_low(i_cipher_low), .i_cipher_high(i_cipher_high),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_plain_low(o_plain_low), .o_plain_high(o_plain_high),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // mirror of the block state
    logic [63:0] data_key_lo, data_key_hi, tweak_key_lo, tweak_key_hi;
    t_key_sched data_sched, tweak_sched;
    logic [127:0] cur_tweak;
    int unsigned blk_in_sector;
    logic [63:0] sector_num;

    t_block cipher_pending[$];
    t_block plain_expected[$];
    int error_count = 0;
    int idle_cycles = 0;

    function automatic t_aes_state to_state(logic [127:0] v);
        t_aes_state s;
        for (int i = 0; i < 16; i++) s[i] = v[8*i +: 8];
        return s;
    endfunction

    function automatic logic [127:0] from_state(t_aes_state s);
        logic [127:0] v;
        for (int i = 0; i < 16; i++) v[8*i +: 8] = s[i];
        return v;
    endfunction

    function automatic logic [7:0] dbl(logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf8_mul(logic [7:0] a, logic [7:0] b);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) r ^= a;
            a = dbl(a);
        end
        return r;
    endfunction

    function automatic t_key_sched expand_key(logic [63:0] lo, logic [63:0] hi);
        logic [7:0] w [176];
        logic [7:0] t [4];
        logic [7:0] tmp, rcon;
        t_key_sched ks;
        rcon = 8'h01;
        for (int i = 0; i < 8; i++) begin
            w[i] = lo[8*i +: 8];
            w[i+8] = hi[8*i +: 8];
        end
        for (int i = 4; i < 44; i++) begin
            for (int j = 0; j < 4; j++) t[j] = w[4*(i-1)+j];
            if (i % 4 == 0) begin
                tmp = t[0];
                t[0] = SBOX[t[1]] ^ rcon;
                t[1] = SBOX[t[2]];
                t[2] = SBOX[t[3]];
                t[3] = SBOX[tmp];
                rcon = dbl(rcon);
            end
            for (int j = 0; j < 4; j++) w[4*i+j] = w[4*(i-4)+j] ^ t[j];
        end
        for (int r = 0; r < 11; r++)
            for (int i = 0; i < 16; i++) ks[r][8*i +: 8] = w[16*r+i];
        return ks;
    endfunction

    function automatic logic [127:0] aes_encrypt(logic [127:0] blk, t_key_sched ks);
        t_aes_state s, t;
        logic [7:0] a0, a1, a2, a3;
        s = to_state(blk ^ ks[0]);
        for (int r = 1; r <= 10; r++) begin
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++) t[i+4*c] = SBOX[s[i+4*((c+i)%4)]];
            s = t;
            if (r < 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                    s[4*c]   = dbl(a0) ^ dbl(a1) ^ a1 ^ a2 ^ a3;
                    s[4*c+1] = a0 ^ dbl(a1) ^ dbl(a2) ^ a2 ^ a3;
                    s[4*c+2] = a0 ^ a1 ^ dbl(a2) ^ dbl(a3) ^ a3;
                    s[4*c+3] = dbl(a0) ^ a0 ^ a1 ^ a2 ^ dbl(a3);
                end
            end
            s = to_state(from_state(s) ^ ks[r]);
        end
        return from_state(s);
    endfunction

    function automatic logic [127:0] aes_decrypt(logic [127:0] blk, t_key_sched ks);
        t_aes_state s, t;
        logic [7:0] a0, a1, a2, a3;
        s = to_state(blk ^ ks[10]);
        for (int r = 9; r >= 0; r--) begin
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++) t[i+4*((c+i)%4)] = INV_SBOX[s[i+4*c]];
            s = to_state(from_state(t) ^ ks[r]);
            if (r > 0) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                    s[4*c]   = gf8_mul(a0, 8'd14) ^ gf8_mul(a1, 8'd11)
                             ^ gf8_mul(a2, 8'd13) ^ gf8_mul(a3, 8'd9);
                    s[4*c+1] = gf8_mul(a0, 8'd9) ^ gf8_mul(a1, 8'd14)
                             ^ gf8_mul(a2, 8'd11) ^ gf8_mul(a3, 8'd13);
                    s[4*c+2] = gf8_mul(a0, 8'd13) ^ gf8_mul(a1, 8'd9)
                             ^ gf8_mul(a2, 8'd14) ^ gf8_mul(a3, 8'd11);
                    s[4*c+3] = gf8_mul(a0, 8'd11) ^ gf8_mul(a1, 8'd13)
                             ^ gf8_mul(a2, 8'd9) ^ gf8_mul(a3, 8'd14);
                end
            end
        end
        return from_state(s);
    endfunction

    // xts decryption of one block, advancing tweak and sector position
    function automatic t_block xts_decrypt_block(t_block c);
        logic [127:0] p;
        t_block res;
        if (blk_in_sector == 0)
            cur_tweak = aes_encrypt({64'h0, sector_num}, tweak_sched);
        p = aes_decrypt({c.hi, c.lo} ^ cur_tweak, data_sched) ^ cur_tweak;
        res.lo = p[63:0];
        res.hi = p[127:64];
        cur_tweak = {cur_tweak[126:0], 1'b0} ^ (cur_tweak[127] ? 128'h87 : 128'h0);
        blk_in_sector++;
        if (blk_in_sector >= BLOCKS_PER_SECTOR) begin
            blk_in_sector = 0;
            sector_num++;
        end
        return res;
    endfunction

    function automatic void apply_reg_write(logic [CFG_AW-1:0] idx, logic [63:0] val);
        case (idx)
            REG_DATA_KEY_LO: begin
                data_key_lo = val;
                data_sched = expand_key(data_key_lo, data_key_hi);
            end
            REG_DATA_KEY_HI: begin
                data_key_hi = val;
                data_sched = expand_key(data_key_lo, data_key_hi);
            end
            REG_TWEAK_KEY_LO: begin
                tweak_key_lo = val;
                tweak_sched = expand_key(tweak_key_lo, tweak_key_hi);
            end
            REG_TWEAK_KEY_HI: begin
                tweak_key_hi = val;
                tweak_sched = expand_key(tweak_key_lo, tweak_key_hi);
            end
            REG_FIRST_SECTOR: begin
                sector_num = val;
                blk_in_sector = 0;
            end
            default: ;
        endcase
    endfunction

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 64'h0;
            1: return '1;
            2: return 64'h1 << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // input driver
    int in_gap = 0;
    int in_burst = 0;
    always @(posedge i_clk) begin
        logic nv;
        t_block item;
        if (i_rst_n) begin
            nv = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                plain_expected.push_back(xts_decrypt_block({i_cipher_low, i_cipher_high}));
                nv = 1'b0;
                if (in_burst > 0) begin
                    in_burst--;
                    in_gap = 0;
                end else begin
                    if ($urandom_range(0, 15) == 0) in_burst = $urandom_range(10, 30);
                    in_gap = $urandom_range(0, 15);
                end
            end
            if (!nv) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (cipher_pending.size() > 0) begin
                    item = cipher_pending.pop_front();
                    nv = 1'b1;
                    i_cipher_low <= item.lo;
                    i_cipher_high <= item.hi;
                end
            end
            i_in_valid <= nv;
        end
    end

    // output monitor and checker
    int out_stall = 0;
    int out_burst = 0;
    always @(posedge i_clk) begin
        t_block want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (plain_expected.size() == 0) begin
                    report_mismatch("unexpected request out", o_plain_low, o_plain_high);
                end else begin
                    want = plain_expected.pop_front();
                    if (o_plain_low !== want.lo) report_mismatch("plain_low", o_plain_low, want.lo);
                    if (o_plain_high !== want.hi)
                        report_mismatch("plain_high", o_plain_high, want.hi);
                end
                if (out_burst > 0) begin
                    out_burst--;
                    out_stall = 0;
                end else begin
                    if ($urandom_range(0, 15) == 0) out_burst = $urandom_range(10, 30);
                    out_stall = $urandom_range(0, 15);
                end
            end else if (out_stall > 0) begin
                out_stall--;
            end
            i_out_ready <= (out_stall == 0);
        end
    end

    // watchdog on cycles without a transfer on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic write_reg(logic [CFG_AW-1:0] idx, logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg_write(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        while (cipher_pending.size() > 0 || i_in_valid || plain_expected.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_random(int n);
        t_block b;
        for (int k = 0; k < n; k++) begin
            b.lo = rand_word();
            b.hi = rand_word();
            cipher_pending.push_back(b);
        end
    endtask

    initial begin
        t_block b;
        logic [63:0] sec;
        data_key_lo = '0; data_key_hi = '0; tweak_key_lo = '0; tweak_key_hi = '0;
        data_sched = expand_key('0, '0);
        tweak_sched = data_sched;
        cur_tweak = '0;
        blk_in_sector = 0;
        sector_num = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all-zero keys, sector zero, field extremes
        write_reg(REG_DATA_KEY_LO, 64'h0);
        write_reg(REG_DATA_KEY_HI, 64'h0);
        write_reg(REG_TWEAK_KEY_LO, 64'h0);
        write_reg(REG_TWEAK_KEY_HI, 64'h0);
        write_reg(REG_FIRST_SECTOR, 64'h0);
        cipher_pending.push_back('{64'h0, 64'h0});
        cipher_pending.push_back('{'1, '1});
        cipher_pending.push_back('{64'h0123456789abcdef, 64'hfedcba9876543210});
        cipher_pending.push_back('{64'h8000000000000000, 64'h1});
        cipher_pending.push_back('{64'h5555555555555555, 64'haaaaaaaaaaaaaaaa});
        cipher_pending.push_back('{64'haaaaaaaaaaaaaaaa, 64'h5555555555555555});
        wait_idle();

        // all-ones keys, unused indexes ignored, top sector number
        write_reg(REG_DATA_KEY_LO, '1);
        write_reg(REG_DATA_KEY_HI, '1);
        write_reg(REG_TWEAK_KEY_LO, '1);
        write_reg(REG_TWEAK_KEY_HI, '1);
        for (int k = REG_SPARE_FIRST; k <= REG_SPARE_LAST; k++)
            write_reg(k[CFG_AW-1:0], rand_word());
        write_reg(REG_FIRST_SECTOR, '1);
        for (int k = 0; k < 8; k++) begin
            b.lo = 64'h1 << (8 * k);
            b.hi = ~(64'h1 << (8 * k + 7));
            cipher_pending.push_back(b);
        end
        wait_idle();

        // sector wrap from the top: cross a sector boundary under partly random keys
        write_reg(REG_DATA_KEY_HI, rand_word());
        write_reg(REG_TWEAK_KEY_LO, rand_word());
        write_reg(REG_FIRST_SECTOR, '1);
        queue_random(BLOCKS_PER_SECTOR + 40);
        wait_idle();

        // random phases, key changes mid-sector keep the tweak running
        for (int ph = 0; ph < 6; ph++) begin
            for (int r = REG_DATA_KEY_LO; r <= REG_TWEAK_KEY_HI; r++)
                if ($urandom_range(0, 1)) write_reg(r[CFG_AW-1:0], rand_word());
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_AW'(REG_SPARE_FIRST + $urandom_range(0, 2)), rand_word());
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 3))
                    0: sec = 64'h0;
                    1: sec = '1;
                    default: sec = rand_word();
                endcase
                write_reg(REG_FIRST_SECTOR, sec);
            end
            queue_random($urandom_range(20, 70));
            wait_idle();
        end

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
hdl/xasd_pkg.sv
hdl/xasd_round.sv
hdl/xasd_key_sched.sv
hdl/xts_aes128_sector_decrypt_top.sv
tb/tb_xts_aes128_sector_decrypt_top.sv
